// File: rtl/bda_pkg.sv
// Shared constants and controller/datapath interface types for the decimal ASCII converter.
package bda_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IN_W        = 32;
    localparam int BIN_W       = (VALUE_WIDTH < IN_W) ? VALUE_WIDTH : IN_W;
    localparam int DIGITS      = 10;
    localparam int BCD_W       = 4 * DIGITS;
    localparam int CHAR_W      = 6;
    localparam int BCNT_W      = (BIN_W > 1) ? $clog2(BIN_W) : 1;
    localparam int DCNT_W      = $clog2(DIGITS);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    typedef struct packed {
        logic load;   // capture a new value, clear the digit register
        logic step;   // one double-dabble iteration
        logic shift;  // drop the top digit
        logic emit;   // present the top digit as a character
        logic last;   // character ends the run
    } t_cmd;

    typedef struct packed {
        logic top_zero;
    } t_sts;

endpackage

// File: rtl/binary_to_decimal_ascii_core.sv
// Top level: converts an unsigned binary value into a run of ASCII decimal characters.
// Sequence: a transaction accepted while idle keeps busy high through BIN_W double-dabble
//   steps, the leading-zero skip (one shift per zero skipped) and the character run;
//   characters strobe on consecutive cycles, MSD first.
// New transactions are taken only while busy is low; the BCD loop converts one bit a cycle.
// Reset: synchronous active-low; clears the controller, the strobe and enable (off).
// The receiver cannot stall: each character is valid for exactly the strobe cycle.
module binary_to_decimal_ascii_core
    import bda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [IN_W-1:0]   i_number,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data,
    output logic              o_strobe,
    output logic [CHAR_W-1:0] o_digit_char,
    output logic              o_last
);

    logic r_enable;
    logic go;
    t_cmd cmd;
    t_sts sts;

    // Enable register; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_enable <= i_cfg_data;
        end
    end

    // A transaction taken while disabled is accepted and dropped: no characters.
    assign go = start && !busy && r_enable;

    bda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bda_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_number     (i_number),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_strobe     (o_strobe),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

    a_char_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_digit_char >= ASCII_ZERO && o_digit_char <= ASCII_ZERO + CHAR_W'(9)))
        else $error("character outside digit range");
    a_disabled_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !r_enable) |=> !busy)
        else $error("disabled transaction started work");
    a_enabled_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && r_enable) |=> busy)
        else $error("enabled transaction was not started");

endmodule

// File: rtl/bda_dpath.sv
// Datapath: binary shift register, BCD digit register and character output register.
module bda_dpath
    import bda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IN_W-1:0]   i_number,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_strobe,
    output logic [CHAR_W-1:0] o_digit_char,
    output logic              o_last
);

    logic [BIN_W-1:0]  r_bin;
    logic [BCD_W-1:0]  r_bcd;
    logic [BCD_W-1:0]  adj;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic              r_strobe;
    logic [3:0]        top;

    assign top = r_bcd[BCD_W-1 -: 4];

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= i_number[BIN_W-1:0];
            r_bcd <= '0;
        end else if (i_cmd.step) begin
            r_bin <= r_bin << 1;
            r_bcd <= {adj[BCD_W-2:0], r_bin[BIN_W-1]};
        end else if (i_cmd.shift) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
        end
        if (i_cmd.emit) begin
            r_char <= ASCII_ZERO + CHAR_W'(top);
            r_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    assign o_sts.top_zero = (top == 4'd0);
    assign o_strobe       = r_strobe;
    assign o_digit_char   = r_char;
    assign o_last         = r_last;

endmodule

// File: rtl/bda_ctrl.sv
// Controller: sequences conversion, leading-zero skip and character emission.
module bda_ctrl
    import bda_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_go,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SKIP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [BCNT_W-1:0] r_bcnt, n_bcnt;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;

    always_comb begin
        n_state = r_state;
        n_bcnt  = r_bcnt;
        n_dcnt  = r_dcnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    o_cmd.load = 1'b1;
                    n_bcnt     = BCNT_W'(BIN_W - 1);
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                if (r_bcnt == '0) begin
                    n_dcnt  = DCNT_W'(DIGITS - 1);
                    n_state = S_SKIP;
                end else begin
                    n_bcnt = r_bcnt - 1'b1;
                end
            end
            S_SKIP: begin
                // drop leading zeros, always keep the final digit
                if (i_sts.top_zero && r_dcnt != '0) begin
                    o_cmd.shift = 1'b1;
                    n_dcnt      = r_dcnt - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit  = 1'b1;
                o_cmd.shift = 1'b1;
                o_cmd.last  = (r_dcnt == '0);
                if (r_dcnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_dcnt = r_dcnt - 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bcnt  <= '0;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_bcnt  <= n_bcnt;
            r_dcnt  <= n_dcnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_emit_only_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> r_state == S_EMIT)
        else $error("emit outside emit state");
    a_conv_runs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && r_bcnt == '0) |=> r_state == S_SKIP)
        else $error("conversion did not end");
    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> r_state == S_IDLE)
        else $error("last character did not end the run");

endmodule

// File: sim/decimal_char_checker.sv
// Checker for the decimal ASCII converter: predicts each character run and compares it.
module decimal_char_checker
    import bda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [IN_W-1:0]   i_number,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic              i_cfg_data,
    input  logic              i_strobe,
    input  logic [CHAR_W-1:0] i_digit_char,
    input  logic              i_last,
    output int                o_mismatch_count,
    output int                o_chars_pending,
    output int                o_chars_checked
);

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } t_char;

    t_char expected_chars[$];
    logic  enable_shadow;

    assign o_chars_pending = expected_chars.size();

    // Queue the decimal characters of one number, most significant digit first.
    function automatic void push_decimal_chars(input logic [IN_W-1:0] number);
        longint unsigned value;
        int              digit_vals[DIGITS];
        int              count;
        t_char           ch;
        value = longint'(number) & ((64'd1 << BIN_W) - 64'd1);
        count = 0;
        do begin
            digit_vals[count] = int'(value % 10);
            value             = value / 10;
            count++;
        end while (value != 0 && count < DIGITS);
        for (int k = 0; k < count; k++) begin
            ch.digit_char = CHAR_W'(ASCII_ZERO + CHAR_W'(digit_vals[count - 1 - k]));
            ch.last       = (k == count - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    always @(posedge i_clk) begin
        t_char want;
        if (!i_rst_n) begin
            enable_shadow = 1'b0;
            expected_chars.delete();
        end else begin
            if (i_strobe) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected character: digit_char=%0d last=%0b",
                           i_digit_char, i_last);
                    o_mismatch_count++;
                end else begin
                    want = expected_chars.pop_front();
                    o_chars_checked++;
                    if (i_digit_char !== want.digit_char) begin
                        $error("digit_char: expected %0d, got %0d",
                               want.digit_char, i_digit_char);
                        o_mismatch_count++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_last);
                        o_mismatch_count++;
                    end
                end
            end
            if (i_start && !i_busy && enable_shadow)
                push_decimal_chars(i_number);
            if (i_cfg_valid && i_cfg_ready)
                enable_shadow = i_cfg_data;
        end
    end

    initial begin
        o_mismatch_count = 0;
        o_chars_checked  = 0;
        enable_shadow    = 1'b0;
    end

endmodule

// File: sim/binary_to_decimal_ascii_core_test.sv
// Testbench top: drives numbers and enable writes into the converter and reports the verdict.
module binary_to_decimal_ascii_core_test;
    import bda_pkg::*;

    // Leave margin after busy drops before touching the enable register.
    localparam int SETTLE_CYCLES = BIN_W + 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 60;
    localparam int IDLE_ITEMS    = 8;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    logic [IN_W-1:0]   i_number    = '0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_data  = 1'b0;
    logic              o_strobe;
    logic [CHAR_W-1:0] o_digit_char;
    logic              o_last;

    int mismatch_count;
    int chars_pending;
    int chars_checked;
    int numbers_sent   = 0;
    int enable_writes  = 0;
    int cycle_count    = 0;

    binary_to_decimal_ascii_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_number     (i_number),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

    decimal_char_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_number         (i_number),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_strobe         (o_strobe),
        .i_digit_char     (o_digit_char),
        .i_last           (o_last),
        .o_mismatch_count (mismatch_count),
        .o_chars_pending  (chars_pending),
        .o_chars_checked  (chars_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a missing character ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("binary_to_decimal_ascii_core: mismatch");
            $finish;
        end
    end

    // Offer one number and hold it until the block takes it. A zero gap keeps start
    // high into the next transaction; otherwise drop start and idle for the gap.
    task automatic send_number(input logic [IN_W-1:0] number, input int gap);
        start    <= 1'b1;
        i_number <= number;
        do @(posedge i_clk); while (busy);
        numbers_sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain all expected characters, then wait out any conversion still running
    // (a disabled transaction never raises busy and produces no output).
    task automatic wait_idle();
        start <= 1'b0;
        while (chars_pending != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        enable_writes++;
    endtask

    // Pick a number of a random decimal length so that every run length shows up,
    // mixed with full-range values that toggle every input bit.
    function automatic logic [IN_W-1:0] random_number();
        longint unsigned lo;
        longint unsigned hi;
        int              len;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        len = $urandom_range(1, DIGITS);
        lo  = 1;
        for (int k = 1; k < len; k++)
            lo = lo * 10;
        hi = lo * 10 - 1;
        if (len == 1)
            lo = 0;
        if (hi > 64'hFFFF_FFFF)
            hi = 64'hFFFF_FFFF;
        return IN_W'(lo + (longint'($urandom) % (hi - lo + 1)));
    endfunction

    // Random gaps, with stretches of back-to-back transactions every so often.
    task automatic run_random(input int count);
        bit back_to_back;
        back_to_back = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (n % 16 == 0)
                back_to_back = ($urandom_range(0, 2) == 0);
            send_number(random_number(), back_to_back ? 0 : $urandom_range(0, 13));
        end
    endtask

    logic [IN_W-1:0] edge_values[$] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
        32'd1000, 32'd10000, 32'd100000, 32'd1000000, 32'd10000000,
        32'd100000000, 32'd999999999, 32'd1000000000, 32'd1234567890,
        32'd2147483647, 32'd2147483648, 32'd4294967294, 32'd4294967295
    };

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Enable comes out of reset clear: these must produce no characters.
        send_number('0, $urandom_range(0, 13));
        send_number('1, $urandom_range(0, 13));
        send_number(32'hFFFF_FFFF, $urandom_range(0, 13));
        wait_idle();

        // Directed pass over the decimal boundaries and the full-scale value.
        write_enable(1'b1);
        foreach (edge_values[k])
            send_number(edge_values[k], $urandom_range(0, 13));
        wait_idle();

        // Random phases: toggle enable between them, rewrite it while already set too.
        run_random(PHASE_ITEMS);
        wait_idle();
        write_enable(1'b0);
        run_random(IDLE_ITEMS);
        wait_idle();
        write_enable(1'b1);
        run_random(PHASE_ITEMS);
        wait_idle();
        write_enable(1'b1);
        run_random(PHASE_ITEMS);
        wait_idle();
        write_enable(1'b0);
        run_random(IDLE_ITEMS);
        wait_idle();
        write_enable(1'b1);
        run_random(PHASE_ITEMS);
        wait_idle();

        $display("Sent %0d numbers across %0d enable writes, enabled and disabled phases.",
                 numbers_sent, enable_writes);
        $display("Checked %0d decimal characters, runs of 1 to %0d digits.",
                 chars_checked, DIGITS);
        if (mismatch_count == 0) begin
            $display("binary_to_decimal_ascii_core: match");
        end else begin
            $display("binary_to_decimal_ascii_core: mismatch");
        end
        $finish;
    end

endmodule
